/* hdl/mtf_pkg.sv */
`timescale 1ns / 1ps

package mtf_pkg;

   // Width of one list entry, one symbol and one rank.
   localparam int SYM_W = 8;

   localparam int ALPHABET_SIZE_DEF = 256;

   // Token that walks down the chain, one cell per cycle.
   // While active it is still searching and carries the entry displaced by the
   // previous cell; once done it carries the result to the end of the chain.
   typedef struct packed {
      logic             active;
      logic             done;
      logic [SYM_W-1:0] carry;
   } token_type;

   // Controls that the top level sends to every cell at once.
   typedef struct packed {
      logic             init;
      logic             front_en;
      logic [SYM_W-1:0] front;
      logic             dir;
      logic [SYM_W-1:0] key;
   } bcast_type;

endpackage

/* hdl/mtf_cell.sv */
`timescale 1ns / 1ps

module mtf_cell #(
   parameter int IDX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  mtf_pkg::bcast_type bcast,
   input  mtf_pkg::token_type tok_in,
   output mtf_pkg::token_type tok_out
);
   import mtf_pkg::*;

   localparam logic [SYM_W-1:0] OWN_IDX = SYM_W'(IDX);

   logic [SYM_W-1:0] entry_ff;
   logic [SYM_W-1:0] entry_in;
   token_type        tok_ff;
   logic             hit;

   // In decode mode the rank picks the cell; in encode mode the symbol does.
   assign hit = tok_ff.active &
                (bcast.dir ? (bcast.key == OWN_IDX) : (entry_ff == bcast.key));

   always_comb begin
      entry_in = entry_ff;
      if (bcast.init) begin
         entry_in = OWN_IDX;
      end else if ((IDX == 0) && bcast.front_en) begin
         entry_in = bcast.front;
      end else if (tok_ff.active) begin
         // Every cell up to and including the hit takes its neighbor's entry.
         entry_in = tok_ff.carry;
      end
   end

   always_comb begin
      tok_out.active = tok_ff.active & ~hit;
      tok_out.done   = tok_ff.done | hit;
      if (hit) begin
         tok_out.carry = bcast.dir ? entry_ff : OWN_IDX;
      end else if (tok_ff.active) begin
         tok_out.carry = entry_ff;
      end else begin
         tok_out.carry = tok_ff.carry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
         tok_ff.done   <= 1'b0;
         entry_ff      <= OWN_IDX;
      end else begin
         tok_ff.active <= tok_in.active;
         tok_ff.done   <= tok_in.done;
         entry_ff      <= entry_in;
      end
      tok_ff.carry <= tok_in.carry;
   end

endmodule

/* hdl/move_to_front_coder.sv */
`timescale 1ns / 1ps
// Channel   Direction  Ports                              Transfer when
// request   in         req_value, req_start_req           req_valid & req_ready
// response  out        rsp_coded                          rsp_valid & rsp_ready
// csr       in         csr_wr_data (direction)            csr_wr_en
//
// The recency list lives in a chain of ALPHABET_SIZE cells, one entry each.
// A token enters the first cell at the edge of a request transfer and moves
// one cell per cycle to the end of the chain; the result is registered into
// the output register or the spare slot once the token leaves the last cell,
// and no new request is taken before then, so the chain length sets the pace.
// Reset loads the identity list at once and clears direction to encode.
// A result not yet taken sits in the output register and a second one in a
// spare slot; requests stall only while an item walks or the spare is full.

module move_to_front_coder #(
   parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [mtf_pkg::SYM_W-1:0] req_value,
   input  logic                      req_start_req,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [mtf_pkg::SYM_W-1:0] rsp_coded,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data
);
   import mtf_pkg::*;

   localparam logic [SYM_W-1:0] MAX_SYM = SYM_W'(ALPHABET_SIZE - 1);

   token_type          tok [0:ALPHABET_SIZE];
   bcast_type          bcast;
   logic [ALPHABET_SIZE-1:0] tok_seen;

   logic             direction_ff;
   logic             busy_ff, busy_in;
   logic [SYM_W-1:0] key_ff, key_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0] rsp_coded_ff, rsp_coded_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0] pend_coded_ff, pend_coded_in;

   logic             accept;
   logic             rsp_take;
   logic             finish;
   logic [SYM_W-1:0] result;
   logic [SYM_W-1:0] key_sat;

   assign req_ready = ~busy_ff & ~pend_valid_ff;
   assign accept    = req_valid & req_ready;
   assign rsp_take  = rsp_valid_ff & rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_coded = rsp_coded_ff;

   assign key_sat = (req_value > MAX_SYM) ? MAX_SYM : req_value;

   assign finish = tok[ALPHABET_SIZE].done;
   assign result = tok[ALPHABET_SIZE].carry;

   assign tok[0].active = accept;
   assign tok[0].done   = 1'b0;
   assign tok[0].carry  = key_sat;

   // The moved symbol lands in the first cell once the walk is over.
   assign bcast.init     = accept & req_start_req;
   assign bcast.front_en = finish;
   assign bcast.front    = direction_ff ? result : key_ff;
   assign bcast.dir      = direction_ff;
   assign bcast.key      = key_ff;

   genvar gi;
   generate
      for (gi = 0; gi < ALPHABET_SIZE; gi++) begin : g_cell
         mtf_cell #(
            .IDX(gi)
         ) u_cell (
            .clock  (clock),
            .reset  (reset),
            .bcast  (bcast),
            .tok_in (tok[gi]),
            .tok_out(tok[gi+1])
         );
         assign tok_seen[gi] = tok[gi+1].active | tok[gi+1].done;
      end
   endgenerate

   always_comb begin
      busy_in = busy_ff;
      key_in  = key_ff;
      if (accept) begin
         busy_in = 1'b1;
         key_in  = key_sat;
      end else if (finish) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_coded_in  = rsp_coded_ff;
      pend_valid_in = pend_valid_ff;
      pend_coded_in = pend_coded_ff;
      if (finish) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_coded_in = result;
         end else begin
            pend_valid_in = 1'b1;
            pend_coded_in = result;
         end
      end else if (rsp_take) begin
         rsp_valid_in  = pend_valid_ff;
         rsp_coded_in  = pend_coded_ff;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff  <= 1'b0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            direction_ff <= csr_wr_data;
         end
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      key_ff        <= key_in;
      rsp_coded_ff  <= rsp_coded_in;
      pend_coded_ff <= pend_coded_in;
   end

`ifndef NO_ASSERTIONS
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_seen))
      else $error("more than one token in the cell chain");

   a_walk_hits: assert property (@(posedge clock) disable iff (reset)
      !tok[ALPHABET_SIZE].active)
      else $error("token left the chain without a match");

   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      finish |-> busy_ff && !pend_valid_ff)
      else $error("walk finished with no item in flight or spare slot full");

   a_pend_order: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("spare result held while output register is empty");
`endif

endmodule
